[rtl/chc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_pkg
// Shared types, constants and codes for the climate humidity controller.
// ----------------------------------------------------------------------------
package chc_pkg;

  localparam int unsigned RISE_FLOOR_DEF      = 20;
  localparam int unsigned MIN_RUN_MINUTES_DEF = 10;
  localparam int unsigned SECONDS_PER_HOUR    = 3600;
  localparam int unsigned FROST_HOLD_SECONDS  = 600;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BAND       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_HUM    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FAN_MARGIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_FROST_TEMP = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_LOW   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HEAT_HIGH  = 3'd7;

  localparam logic [2:0] DC_FROST    = 3'd0;
  localparam logic [2:0] DC_START    = 3'd1;
  localparam logic [2:0] DC_OK       = 3'd2;
  localparam logic [2:0] DC_MIN_RUN  = 3'd3;
  localparam logic [2:0] DC_DRY_STOP = 3'd4;
  localparam logic [2:0] DC_DRYING   = 3'd5;

  localparam logic [2:0] HC_COLD     = 3'd0;
  localparam logic [2:0] HC_HOT      = 3'd1;
  localparam logic [2:0] HC_HOLD     = 3'd2;
  localparam logic [2:0] HC_EXPIRED  = 3'd3;
  localparam logic [2:0] HC_NONE     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture item, start rate calc
    logic div_step;  // one quotient bit
    logic mul;       // drop product
    logic decide;    // thresholds + decisions, update state
  } chc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_done;
  } chc_sts_t;

endpackage

[rtl/chc_datapath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_datapath
// Item registers, restoring divider for the rise rate, gain multiply and the
// relay decisions with their persistent state.
// ----------------------------------------------------------------------------
module chc_datapath #(
  parameter int unsigned RISE_FLOOR      = chc_pkg::RISE_FLOOR_DEF,
  parameter int unsigned MIN_RUN_MINUTES = chc_pkg::MIN_RUN_MINUTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  chc_pkg::chc_cmd_t             cmd,
  output chc_pkg::chc_sts_t             sts,
  input  logic                          cfg_we,
  input  logic [chc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic [31:0]                   in_now_seconds,
  input  logic [9:0]                    in_hum_indoor,
  input  logic signed [11:0]            in_temp_indoor,
  input  logic [9:0]                    in_hum_outdoor,
  input  logic signed [11:0]            in_temp_outdoor,
  input  logic                          in_dehum_running,
  input  logic                          in_heater_running,
  input  logic                          in_timer_load,
  input  logic [31:0]                   in_timer_until,
  output logic                          out_fan_on,
  output logic [1:0]                    out_fan_cause,
  output logic                          out_dehum_on,
  output logic [2:0]                    out_dehum_cause,
  output logic                          out_heater_on,
  output logic [2:0]                    out_heater_cause,
  output logic                          out_frost_heat,
  output logic                          out_manual_timer_active,
  output logic [15:0]                   out_rise_rate,
  output logic signed [10:0]            out_on_threshold,
  output logic signed [10:0]            out_off_threshold
);
  import chc_pkg::*;

  localparam logic [31:0] MIN_RUN_S = 32'(MIN_RUN_MINUTES * 60);
  localparam logic [16:0] RISE_FLOOR_V = 17'(RISE_FLOOR);
  // numerator dh*3600 < 2^22
  localparam int NUM_W = 22;
  localparam logic [4:0] DIV_LAST = 5'(NUM_W - 1);

  // configuration
  logic [9:0]         on_level_r, band_r, fan_hum_r;
  logic [15:0]        gain_r;
  logic signed [9:0]  fan_margin_r;
  logic signed [11:0] frost_temp_r, heat_low_r, heat_high_r;

  // persistent state
  logic [9:0]  last_hum_r;
  logic        have_last_r;
  logic [31:0] last_time_r, dstart_r, deadline_r;

  // item
  logic [31:0]        now_r;
  logic [9:0]         hin_r, hout_r;
  logic signed [11:0] tin_r, tout_r;
  logic               drun_r, hrun_r;

  // divider
  logic [NUM_W-1:0] num_r;
  logic [31:0]      rem_r;
  logic [NUM_W-1:0] quo_r;
  logic [31:0]      dt_r;
  logic [4:0]       bit_r;
  logic             rate_ok_r;
  logic [16:0]      rate_r;  // already saturated to 16 bits when written
  logic [31:0]      prod_r;

  logic signed [10:0] dh;
  logic [31:0]        dt_w;
  logic [32:0]        rem_sh;
  logic [31:0]        dl_eff;
  logic [15:0]        rate_sat;

  always_comb begin
    dh       = 11'($signed({1'b0, in_hum_outdoor})) - 11'($signed({1'b0, last_hum_r}));
    dt_w     = in_now_seconds - last_time_r;
    rem_sh   = {rem_r, num_r[DIV_LAST]};
    dl_eff   = in_timer_load ? in_timer_until : deadline_r;
    rate_sat = (quo_r > NUM_W'(65535)) ? 16'hFFFF : 16'(quo_r);
  end

  assign sts.div_done = (bit_r == DIV_LAST);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      on_level_r   <= 10'd650;
      band_r       <= 10'd50;
      gain_r       <= 16'd256;
      fan_hum_r    <= 10'd600;
      fan_margin_r <= 10'sd20;
      frost_temp_r <= 12'sd50;
      heat_low_r   <= 12'sd80;
      heat_high_r  <= 12'sd120;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ON_LEVEL:   on_level_r   <= cfg_data[9:0];
        REG_BAND:       band_r       <= cfg_data[9:0];
        REG_GAIN:       gain_r       <= cfg_data;
        REG_FAN_HUM:    fan_hum_r    <= cfg_data[9:0];
        REG_FAN_MARGIN: fan_margin_r <= $signed(cfg_data[9:0]);
        REG_FROST_TEMP: frost_temp_r <= $signed(cfg_data[11:0]);
        REG_HEAT_LOW:   heat_low_r   <= $signed(cfg_data[11:0]);
        REG_HEAT_HIGH:  heat_high_r  <= $signed(cfg_data[11:0]);
        default: ;
      endcase
    end
  end

  // item capture and divider
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r  <= in_now_seconds;
      hin_r  <= in_hum_indoor;
      hout_r <= in_hum_outdoor;
      tin_r  <= in_temp_indoor;
      tout_r <= in_temp_outdoor;
      drun_r <= in_dehum_running;
      hrun_r <= in_heater_running;
      rate_ok_r <= have_last_r && (last_time_r != 32'd0);
      num_r  <= (have_last_r && last_time_r != 32'd0 && in_now_seconds > last_time_r
                 && dh > 11'sd0)
                ? NUM_W'(dh[9:0]) * NUM_W'(SECONDS_PER_HOUR) : '0;
      dt_r   <= (dt_w == 32'd0) ? 32'd1 : dt_w;
      rem_r  <= '0;
      quo_r  <= '0;
      bit_r  <= '0;
    end else if (cmd.div_step) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      if (rem_sh >= {1'b0, dt_r}) begin
        rem_r <= rem_sh[31:0] - dt_r;
        quo_r <= {quo_r[NUM_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[31:0];
        quo_r <= {quo_r[NUM_W-2:0], 1'b0};
      end
      bit_r <= bit_r + 5'd1;
    end
    if (cmd.mul) begin
      rate_r <= {1'b0, rate_sat};
      prod_r <= {16'd0, gain_r} * {16'd0, rate_sat};
    end
  end

  // decisions
  logic [16:0]        rate_f;
  logic               apply;
  logic [23:0]        drop;
  logic signed [12:0] on_lvl, band, thr_on, thr_off, min_on;
  logic               humid, cold, fan, frost_heat, dehum, manual, heater;
  logic [2:0]         dc, hc;
  logic [31:0]        new_start, new_dl;
  logic signed [32:0] elapsed;
  logic signed [13:0] tsum;

  always_comb begin
    rate_f = (rate_ok_r && rate_r >= RISE_FLOOR_V) ? rate_r : 17'd0;
    on_lvl = 13'($signed({1'b0, on_level_r}));
    band   = 13'($signed({1'b0, band_r}));
    min_on = on_lvl - band;
    drop   = prod_r[31:8];
    apply  = rate_ok_r && rate_r >= RISE_FLOOR_V
             && ({7'd0, hout_r} + rate_r > {7'd0, hin_r});
    thr_on = on_lvl;
    if (apply) begin
      if (drop > {14'd0, band_r}) thr_on = min_on;
      else thr_on = on_lvl - 13'($signed({1'b0, drop[9:0]}));
    end
    thr_off = thr_on - band;

    humid = hout_r >= fan_hum_r;
    tsum  = 14'(tin_r) + 14'(fan_margin_r);
    cold  = 14'(tout_r) <= tsum;
    fan   = !humid && !cold;

    dehum = 1'b0; frost_heat = 1'b0; new_start = dstart_r;
    elapsed = $signed({1'b0, now_r}) - $signed({1'b0, dstart_r});
    if (tin_r < frost_temp_r) begin
      dc = DC_FROST; new_start = '0;
      frost_heat = 13'($signed({1'b0, hin_r})) >= thr_on;
    end else if (!drun_r) begin
      if (13'($signed({1'b0, hin_r})) >= thr_on) begin
        dehum = 1'b1; dc = DC_START; new_start = now_r;
      end else dc = DC_OK;
    end else if (dstart_r != 32'd0 && elapsed < $signed({1'b0, MIN_RUN_S})) begin
      dehum = 1'b1; dc = DC_MIN_RUN;
    end else if (13'($signed({1'b0, hin_r})) < min_on) begin
      dc = DC_DRY_STOP; new_start = '0;
    end else begin
      dehum = 1'b1; dc = DC_DRYING;
    end

    new_dl = deadline_r;
    manual = deadline_r != 32'd0 && now_r < deadline_r;
    heater = 1'b0;
    if (frost_heat && !manual) new_dl = now_r + 32'(FROST_HOLD_SECONDS);
    if (manual || frost_heat) begin
      if (tin_r < heat_low_r) begin heater = 1'b1; hc = HC_COLD; end
      else if (tin_r >= heat_high_r) hc = HC_HOT;
      else begin heater = hrun_r; hc = HC_HOLD; end
    end else if (deadline_r != 32'd0) begin
      hc = HC_EXPIRED; new_dl = '0;
    end else hc = HC_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_hum_r  <= '0;
      have_last_r <= 1'b0;
      last_time_r <= '0;
      dstart_r    <= '0;
      deadline_r  <= '0;
    end else if (cmd.load) begin
      deadline_r <= dl_eff;
    end else if (cmd.decide) begin
      last_hum_r  <= hout_r;
      have_last_r <= 1'b1;
      last_time_r <= now_r;
      dstart_r    <= new_start;
      deadline_r  <= new_dl;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      out_fan_on              <= fan;
      out_fan_cause           <= {cold, humid};
      out_dehum_on            <= dehum;
      out_dehum_cause         <= dc;
      out_heater_on           <= heater;
      out_heater_cause        <= hc;
      out_frost_heat          <= frost_heat;
      out_manual_timer_active <= manual;
      out_rise_rate           <= rate_f[15:0];
      out_on_threshold        <= thr_on[10:0];
      out_off_threshold       <= (thr_off < -13'sd1024) ? 11'h400 : thr_off[10:0];
    end
  end

endmodule

[rtl/chc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_ctrl
// Sequencer: accept, divide, multiply, decide, present result.
// ----------------------------------------------------------------------------
module chc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output chc_pkg::chc_cmd_t cmd,
  input  chc_pkg::chc_sts_t sts
);
  import chc_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DIV, S_MUL, S_DEC, S_OUT} state_t;
  state_t state_r;
  logic   out_valid_r;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.div_step = (state_r == S_DIV);
    cmd.mul      = (state_r == S_MUL);
    cmd.decide   = (state_r == S_DEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DIV;
        S_DIV:  if (sts.div_done) state_r <= S_MUL;
        S_MUL:  state_r <= S_DEC;
        S_DEC: begin
          out_valid_r <= 1'b1;
          state_r     <= S_OUT;
        end
        S_OUT: if (!out_stall) begin
          out_valid_r <= 1'b0;
          state_r     <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/climate_humidity_controller_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// climate_humidity_controller_top
// Humidity/temperature relay controller with rise-rate threshold lowering.
//
//  channel | ports                    | handshake
//  in      | in_* fields              | in_valid / in_stall
//  out     | out_* fields             | out_valid / out_stall
//  cfg     | cfg_we, cfg_index, cfg_data | write, no wait
//
// The result is valid once the bit-serial rate divider has finished, followed
// by multiply and decide. The next item is accepted the cycle after the
// result is taken, so only one item is in flight at a time.
// Synchronous active-low reset; no clearing pass.
// ----------------------------------------------------------------------------
module climate_humidity_controller_top #(
  parameter int unsigned RISE_FLOOR      = chc_pkg::RISE_FLOOR_DEF,
  parameter int unsigned MIN_RUN_MINUTES = chc_pkg::MIN_RUN_MINUTES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [chc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [31:0]                    in_now_seconds,
  input  logic [9:0]                     in_hum_indoor,
  input  logic signed [11:0]             in_temp_indoor,
  input  logic [9:0]                     in_hum_outdoor,
  input  logic signed [11:0]             in_temp_outdoor,
  input  logic                           in_dehum_running,
  input  logic                           in_heater_running,
  input  logic                           in_timer_load,
  input  logic [31:0]                    in_timer_until,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic                           out_fan_on,
  output logic [1:0]                     out_fan_cause,
  output logic                           out_dehum_on,
  output logic [2:0]                     out_dehum_cause,
  output logic                           out_heater_on,
  output logic [2:0]                     out_heater_cause,
  output logic                           out_frost_heat,
  output logic                           out_manual_timer_active,
  output logic [15:0]                    out_rise_rate,
  output logic signed [10:0]             out_on_threshold,
  output logic signed [10:0]             out_off_threshold
);
  import chc_pkg::*;

  chc_cmd_t cmd;
  chc_sts_t sts;

  chc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .cmd, .sts
  );

  chc_datapath #(.RISE_FLOOR(RISE_FLOOR), .MIN_RUN_MINUTES(MIN_RUN_MINUTES)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_now_seconds, .in_hum_indoor, .in_temp_indoor, .in_hum_outdoor,
    .in_temp_outdoor, .in_dehum_running, .in_heater_running, .in_timer_load,
    .in_timer_until, .out_fan_on, .out_fan_cause, .out_dehum_on,
    .out_dehum_cause, .out_heater_on, .out_heater_cause, .out_frost_heat,
    .out_manual_timer_active, .out_rise_rate, .out_on_threshold,
    .out_off_threshold
  );

endmodule

[rtl/chc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chc_checker
// Port-level checks on the top level, attached by bind.
// ----------------------------------------------------------------------------
module chc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_rise_rate
);
  // one item in flight: no accept while a result is shown
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("accept while result pending");
  // accepted item blocks further input next cycle
  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall) else $error("no stall after accept");
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_rise_rate)))
    else $error("result dropped under stall");
endmodule

bind climate_humidity_controller_top chc_checker u_chc_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_rise_rate
);
